[hdl/tbpu_pkg.sv]
package tbpu_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam int unsigned VADDR_W = 14;
  localparam int unsigned PAT_W   = 13;
  localparam int unsigned NT_W    = 11;

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [VADDR_W-1:0] addr;
    logic [7:0]         data;
  } vmem_req_t;

endpackage

[hdl/tbpu_vmem.sv]
module tbpu_vmem
  import tbpu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       mirror_vertical,
  input  vmem_req_t  req,
  output logic [7:0] rd_data,
  output logic       busy
);

  logic [7:0]       pat_mem [2**PAT_W];
  logic [7:0]       nt_mem  [2**NT_W];
  logic [PAT_W-1:0] clr_cnt_r;
  logic             busy_r;
  logic [7:0]       pat_q_r;
  logic [7:0]       nt_q_r;
  logic             sel_nt_r;
  logic             is_nt;
  logic [NT_W-1:0]  nt_idx;

  assign is_nt  = req.addr[13];
  assign nt_idx = {(mirror_vertical ? req.addr[10] : req.addr[11]), req.addr[9:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (&clr_cnt_r) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      pat_mem[clr_cnt_r] <= 8'h00;
    end else if (req.wr && !is_nt) begin
      pat_mem[req.addr[PAT_W-1:0]] <= req.data;
    end
    if (req.rd) pat_q_r <= pat_mem[req.addr[PAT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      nt_mem[clr_cnt_r[NT_W-1:0]] <= 8'h00;
    end else if (req.wr && is_nt) begin
      nt_mem[nt_idx] <= req.data;
    end
    if (req.rd) nt_q_r <= nt_mem[nt_idx];
  end

  always_ff @(posedge clk) begin
    if (req.rd) sel_nt_r <= is_nt;
  end

  assign rd_data = sel_nt_r ? nt_q_r : pat_q_r;
  assign busy    = busy_r;

endmodule

[hdl/tile_background_picture_unit.sv]
// channel | signals                          | payload
// in      | in_tvalid/in_tready              | tdata: reg_addr[2:0] write_data[10:3]; tuser: kind
// out     | out_tvalid/out_tready            | tdata: read_data, pixel_x, pixel_y, pixel_color, nmi
//         |                                  | tuser: pixel_valid; tlast: frame_done
// cfg     | cfg_valid/cfg_ready              | cfg_data: mirror_vertical
//
// One item per cycle unless memory is clearing or the output stalls; each item is done
// in the cycle it is accepted and its result is registered. Video memory reads land in
// the cycle after the request and are forwarded to the next item. After reset a
// clearing pass zeroes pattern and nametable memory; no item is accepted meanwhile.
// A stalled output holds; input is taken again as soon as the output register frees.
module tile_background_picture_unit
  import tbpu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // reg_addr[2:0], write_data[10:3]
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data, pixel_x, pixel_y, pixel_color, nmi
  output logic        out_tuser,  // pixel_valid
  output logic        out_tlast,  // frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic              mv_r;
  logic [8:0]        dot_r, dot_nxt;
  logic signed [9:0] line_r, line_nxt;
  logic [7:0]        ctrl_r, ctrl_nxt, mask_r, mask_nxt;
  logic              vb_r, vb_nxt, wt_r, wt_nxt;
  logic [7:0]        rb_r, rb_nxt;
  logic [15:0]       v_r, v_nxt, t_r, t_nxt;
  logic [2:0]        fx_r, fx_nxt;
  logic [7:0]        nt_r, nt_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [1:0]        at_r, at_nxt;
  logic [15:0]       sh_r [4];
  logic [15:0]       sh_nxt [4];
  logic [7:0]        pal_r [32];
  logic [7:0]        pal_nxt [32];
  logic              rb_pend_r, nt_pend_r, at_pend_r, lo_pend_r, hi_pend_r;
  logic              rb_pend_nxt, nt_pend_nxt, at_pend_nxt, lo_pend_nxt, hi_pend_nxt;
  logic [1:0]        at_sh_r, at_sh_nxt;
  logic              out_valid_r;
  logic [31:0]       out_data_r, out_data_nxt;
  logic              out_user_r, out_user_nxt, out_last_r, out_last_nxt;

  logic [7:0]        mem_q;
  logic              mem_busy;
  vmem_req_t         req;
  logic              in_fire;
  logic [7:0]        rb_eff, nt_eff, lo_eff, hi_eff, at_byte;
  logic [1:0]        at_eff;

  tbpu_vmem u_vmem (
    .clk             (clk),
    .rst_n           (rst_n),
    .mirror_vertical (mv_r),
    .req             (req),
    .rd_data         (mem_q),
    .busy            (mem_busy)
  );

  assign in_tready = !mem_busy && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign rb_eff  = rb_pend_r ? mem_q : rb_r;
  assign nt_eff  = nt_pend_r ? mem_q : nt_r;
  assign lo_eff  = lo_pend_r ? mem_q : lo_r;
  assign hi_eff  = hi_pend_r ? mem_q : hi_r;
  assign at_byte = mem_q >> {at_sh_r, 1'b0};
  assign at_eff  = at_pend_r ? at_byte[1:0] : at_r;

  function automatic logic [4:0] pal_idx(input logic [4:0] a);
    pal_idx = (a[4] && a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a;
  endfunction

  always_comb begin
    logic [2:0]  ra;
    logic [7:0]  wd;
    logic [8:0]  d;
    logic [2:0]  ph;
    logic [4:0]  cy;
    logic [15:0] inc;
    logic        rendering;
    logic [15:0] bit_sel;
    logic [1:0]  pix, pal;
    logic [4:0]  pa;
    logic [7:0]  pv;
    logic [7:0]  rd_val;
    logic        nmi, pvalid, fdone;
    logic [7:0]  px, py;
    logic [5:0]  pcol;

    ra = in_tdata[2:0];
    wd = in_tdata[10:3];
    d  = dot_r;
    ph = '0;
    cy = '0;
    inc = ctrl_r[2] ? 16'd32 : 16'd1;
    rendering = mask_r[4] || mask_r[3];
    bit_sel = '0;
    pix = '0;
    pal = '0;
    pa  = '0;
    pv  = '0;
    rd_val = '0;
    nmi = 1'b0;
    pvalid = 1'b0;
    fdone = 1'b0;
    px = '0;
    py = '0;
    pcol = '0;

    dot_nxt  = dot_r;
    line_nxt = line_r;
    ctrl_nxt = ctrl_r;
    mask_nxt = mask_r;
    vb_nxt   = vb_r;
    wt_nxt   = wt_r;
    v_nxt    = v_r;
    t_nxt    = t_r;
    fx_nxt   = fx_r;
    rb_nxt   = rb_eff;
    nt_nxt   = nt_eff;
    at_nxt   = at_eff;
    lo_nxt   = lo_eff;
    hi_nxt   = hi_eff;
    at_sh_nxt = at_sh_r;
    for (int i = 0; i < 4; i++) sh_nxt[i] = sh_r[i];
    for (int i = 0; i < 32; i++) pal_nxt[i] = pal_r[i];
    rb_pend_nxt = 1'b0;
    nt_pend_nxt = 1'b0;
    at_pend_nxt = 1'b0;
    lo_pend_nxt = 1'b0;
    hi_pend_nxt = 1'b0;
    req = '0;

    if (in_fire) begin
      unique case (in_tuser)
        KIND_TICK: begin
          if (line_r < 10'sd240) begin
            if (line_r == 10'sd0 && d == 9'd0) d = 9'd1;
            if (line_r == -10'sd1 && d == 9'd1) vb_nxt = 1'b0;
            if ((d >= 9'd2 && d < 9'd258) || (d >= 9'd321 && d < 9'd338)) begin
              if (mask_r[3]) begin
                for (int i = 0; i < 4; i++) sh_nxt[i] = {sh_nxt[i][14:0], 1'b0};
              end
              ph = d[2:0] - 3'd1;
              unique case (ph)
                3'd0: begin
                  sh_nxt[0] = {sh_nxt[0][15:8], lo_eff};
                  sh_nxt[1] = {sh_nxt[1][15:8], hi_eff};
                  sh_nxt[2] = {sh_nxt[2][15:8], {8{at_eff[0]}}};
                  sh_nxt[3] = {sh_nxt[3][15:8], {8{at_eff[1]}}};
                  req.rd = 1'b1;
                  req.addr = {2'b10, v_r[11:0]};
                  nt_pend_nxt = 1'b1;
                end
                3'd2: begin
                  req.rd = 1'b1;
                  req.addr = {2'b10, v_r[11:10], 4'b1111, v_r[9:7], v_r[4:2]};
                  at_sh_nxt = {v_r[6], v_r[1]};
                  at_pend_nxt = 1'b1;
                end
                3'd4: begin
                  req.rd = 1'b1;
                  req.addr = {1'b0, ctrl_r[4], nt_eff, 1'b0, v_r[14:12]};
                  lo_pend_nxt = 1'b1;
                end
                3'd6: begin
                  req.rd = 1'b1;
                  req.addr = {1'b0, ctrl_r[4], nt_eff, 1'b1, v_r[14:12]};
                  hi_pend_nxt = 1'b1;
                end
                3'd7: begin
                  if (rendering) begin
                    if (v_nxt[4:0] == 5'd31) v_nxt = {v_nxt[15:11], ~v_nxt[10], v_nxt[9:5], 5'd0};
                    else v_nxt = v_nxt + 16'd1;
                  end
                end
                default: ;
              endcase
            end
            if (d == 9'd256 && rendering) begin
              if (v_nxt[14:12] != 3'b111) begin
                v_nxt = v_nxt + 16'h1000;
              end else begin
                v_nxt[14:12] = 3'b000;
                cy = v_nxt[9:5];
                if (cy == 5'd29) begin
                  cy = 5'd0;
                  v_nxt[11] = ~v_nxt[11];
                end else if (cy == 5'd31) begin
                  cy = 5'd0;
                end else begin
                  cy = cy + 5'd1;
                end
                v_nxt[9:5] = cy;
              end
            end
            if (d == 9'd257) begin
              sh_nxt[0] = {sh_nxt[0][15:8], lo_eff};
              sh_nxt[1] = {sh_nxt[1][15:8], hi_eff};
              sh_nxt[2] = {sh_nxt[2][15:8], {8{at_eff[0]}}};
              sh_nxt[3] = {sh_nxt[3][15:8], {8{at_eff[1]}}};
              if (rendering) begin
                v_nxt[10]  = t_r[10];
                v_nxt[4:0] = t_r[4:0];
              end
            end
            if (d == 9'd338 || d == 9'd340) begin
              req.rd = 1'b1;
              req.addr = {2'b10, v_nxt[11:0]};
              nt_pend_nxt = 1'b1;
            end
            if (line_r == -10'sd1 && d >= 9'd280 && d < 9'd305 && rendering) begin
              v_nxt[14:11] = t_r[14:11];
              v_nxt[9:5]   = t_r[9:5];
            end
          end
          if (line_r == 10'sd241 && d == 9'd1) begin
            vb_nxt = 1'b1;
            nmi = ctrl_r[7];
          end
          if (line_r >= 10'sd0 && line_r < 10'sd240 && d >= 9'd1 && d <= 9'd256) begin
            if (mask_r[3]) begin
              bit_sel = 16'h8000 >> fx_r;
              pix = {|(sh_nxt[1] & bit_sel), |(sh_nxt[0] & bit_sel)};
              pal = {|(sh_nxt[3] & bit_sel), |(sh_nxt[2] & bit_sel)};
            end
            if (pix == 2'd0) pal = 2'd0;
            pa = {1'b0, pal, pix};
            pv = pal_r[pal_idx(pa)] & (mask_r[0] ? 8'h30 : 8'h3F);
            pvalid = 1'b1;
            px = 8'(d - 9'd1);
            py = line_r[7:0];
            pcol = pv[5:0];
          end
          d = d + 9'd1;
          if (d >= 9'd341) begin
            d = 9'd0;
            line_nxt = line_r + 10'sd1;
            if (line_nxt >= 10'sd261) begin
              line_nxt = -10'sd1;
              fdone = 1'b1;
            end
          end
          dot_nxt = d;
        end
        KIND_READ: begin
          if (ra == REG_STATUS) begin
            rd_val = {vb_r, 2'b00, rb_eff[4:0]};
            vb_nxt = 1'b0;
            wt_nxt = 1'b0;
          end else if (ra == REG_DATA) begin
            if (v_r[13:8] == 6'h3F) begin
              pv = pal_r[pal_idx(v_r[4:0])] & (mask_r[0] ? 8'h30 : 8'h3F);
              rb_nxt = pv;
              rd_val = pv;
            end else begin
              rd_val = rb_eff;
              req.rd = 1'b1;
              req.addr = v_r[13:0];
              rb_pend_nxt = 1'b1;
            end
            v_nxt = v_r + inc;
          end
        end
        KIND_WRITE: begin
          unique case (ra)
            REG_CTRL: begin
              ctrl_nxt = wd;
              t_nxt[11:10] = wd[1:0];
            end
            REG_MASK: mask_nxt = wd;
            REG_SCROLL: begin
              if (!wt_r) begin
                fx_nxt = wd[2:0];
                t_nxt[4:0] = wd[7:3];
                wt_nxt = 1'b1;
              end else begin
                t_nxt[14:12] = wd[2:0];
                t_nxt[9:5] = wd[7:3];
                wt_nxt = 1'b0;
              end
            end
            REG_ADDR: begin
              if (!wt_r) begin
                t_nxt = {2'b00, wd[5:0], t_r[7:0]};
                wt_nxt = 1'b1;
              end else begin
                t_nxt = {t_r[15:8], wd};
                v_nxt = {t_r[15:8], wd};
                wt_nxt = 1'b0;
              end
            end
            REG_DATA: begin
              if (v_r[13:8] == 6'h3F) begin
                pal_nxt[pal_idx(v_r[4:0])] = wd;
              end else begin
                req.wr = 1'b1;
                req.addr = v_r[13:0];
                req.data = wd;
              end
              v_nxt = v_r + inc;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    out_data_nxt = {1'b0, nmi, pcol, py, px, rd_val};
    out_user_nxt = pvalid;
    out_last_nxt = fdone;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      dot_r <= '0;
      line_r <= '0;
      ctrl_r <= '0;
      mask_r <= '0;
      vb_r <= 1'b0;
      wt_r <= 1'b0;
      rb_r <= '0;
      v_r <= '0;
      t_r <= '0;
      fx_r <= '0;
      nt_r <= '0;
      at_r <= '0;
      lo_r <= '0;
      hi_r <= '0;
      at_sh_r <= '0;
      rb_pend_r <= 1'b0;
      nt_pend_r <= 1'b0;
      at_pend_r <= 1'b0;
      lo_pend_r <= 1'b0;
      hi_pend_r <= 1'b0;
      for (int i = 0; i < 4; i++) sh_r[i] <= '0;
      for (int i = 0; i < 32; i++) pal_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) mv_r <= cfg_data;
      dot_r <= dot_nxt;
      line_r <= line_nxt;
      ctrl_r <= ctrl_nxt;
      mask_r <= mask_nxt;
      vb_r <= vb_nxt;
      wt_r <= wt_nxt;
      rb_r <= rb_nxt;
      v_r <= v_nxt;
      t_r <= t_nxt;
      fx_r <= fx_nxt;
      nt_r <= nt_nxt;
      at_r <= at_nxt;
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      at_sh_r <= at_sh_nxt;
      rb_pend_r <= rb_pend_nxt;
      nt_pend_r <= nt_pend_nxt;
      at_pend_r <= at_pend_nxt;
      lo_pend_r <= lo_pend_nxt;
      hi_pend_r <= hi_pend_nxt;
      for (int i = 0; i < 4; i++) sh_r[i] <= sh_nxt[i];
      for (int i = 0; i < 32; i++) pal_r[i] <= pal_nxt[i];
      if (in_fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

[hdl/tbpu_checker.sv]
module tbpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_pix_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == 8'h00)
    else $error("pixel transfer carries read data");

  a_nmi_no_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30] |-> !out_tuser && !out_tlast)
    else $error("nmi together with pixel or frame end");

  a_frame_no_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser && out_tdata[29:0] == 30'd0)
    else $error("frame end with pixel data");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[23:16] < 8'd240)
    else $error("pixel row out of range");

endmodule

bind tile_background_picture_unit tbpu_checker u_tbpu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
